>>> hdl/tsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types, constants and helpers of the timed sample interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int ANGLE_W         = 26;
   localparam int TIME_W          = 32;
   localparam int NUM_ANGLES      = 4;
   localparam int ANG_WORD_W      = ANGLE_W * NUM_ANGLES;
   localparam int CNT_W           = 11;
   localparam int FRAC_W          = 16;
   localparam int S_W             = FRAC_W + 1;
   localparam int DIV_STEPS       = S_W;
   localparam int DIFF_W          = TIME_W + 2;
   localparam int PROD_W          = DIFF_W + S_W + 1;
   localparam int LANE_W          = 3;
   localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(NUM_ANGLES);

   localparam logic signed [ANGLE_W:0] HALF_TURN = (ANGLE_W+1)'(180 * 65536);
   localparam logic signed [ANGLE_W:0] FULL_TURN = (ANGLE_W+1)'(360 * 65536);
   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(1024);

   // Register byte addresses.
   localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;

   typedef enum logic [2:0] {
      ST_INTERP = 3'd0,
      ST_FIRST  = 3'd1,
      ST_PAST   = 3'd2,
      ST_ZERO   = 3'd3,
      ST_LOADED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_PREV_RD,
      S_PREV_CAP,
      S_DIV,
      S_MUL,
      S_ACC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       take_item;
      logic       scan_first;
      logic       scan_next;
      logic       rd_prev;
      logic       cap_cur;
      logic       cap_prev;
      logic       div_step;
      logic       mul_step;
      logic       acc_step;
      logic       set_status;
      status_type status;
      logic       out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_query;
      logic count_zero;
      logic hit;
      logic idx_zero;
      logic zero_interval;
      logic last_entry;
      logic div_last;
      logic lane_last;
      logic out_free;
   } dp_stat_type;

   // Angles above a half turn are brought down by a full turn.
   function automatic logic signed [ANGLE_W:0] wrap_angle(input logic signed [ANGLE_W-1:0] v);
      logic signed [ANGLE_W:0] x;
      x = (ANGLE_W+1)'(v);
      return (x > HALF_TURN) ? x - FULL_TURN : x;
   endfunction

endpackage
`default_nettype wire

>>> hdl/tsi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_ctrl
// Sequencer: table walk, neighbor fetch, divide, blend and result hand-off.
// ----------------------------------------------------------------------------
module tsi_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  tsi_pkg::dp_stat_type stat,
   output tsi_pkg::ctl_cmd_type cmd
);

   tsi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsi_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsi_pkg::S_IDLE: begin
            if (req_tvalid) begin
               if (stat.is_query && !stat.count_zero) state_in = tsi_pkg::S_SCAN_RD;
               else state_in = tsi_pkg::S_DONE;
            end
         end
         tsi_pkg::S_SCAN_RD:  state_in = tsi_pkg::S_SCAN_CMP;
         tsi_pkg::S_SCAN_CMP: begin
            if (stat.hit) begin
               if (stat.idx_zero || stat.zero_interval) state_in = tsi_pkg::S_DONE;
               else state_in = tsi_pkg::S_PREV_RD;
            end else if (stat.last_entry) begin
               state_in = tsi_pkg::S_DONE;
            end else begin
               state_in = tsi_pkg::S_SCAN_RD;
            end
         end
         tsi_pkg::S_PREV_RD:  state_in = tsi_pkg::S_PREV_CAP;
         tsi_pkg::S_PREV_CAP: state_in = tsi_pkg::S_DIV;
         tsi_pkg::S_DIV: begin
            if (stat.div_last) state_in = tsi_pkg::S_MUL;
         end
         tsi_pkg::S_MUL: state_in = tsi_pkg::S_ACC;
         tsi_pkg::S_ACC: begin
            if (stat.lane_last) state_in = tsi_pkg::S_DONE;
            else state_in = tsi_pkg::S_MUL;
         end
         tsi_pkg::S_DONE: begin
            if (stat.out_free) state_in = tsi_pkg::S_IDLE;
         end
         default: state_in = tsi_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = tsi_pkg::ST_INTERP;
      req_tready = 1'b0;
      case (state_ff)
         tsi_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               if (!stat.is_query) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = tsi_pkg::ST_LOADED;
               end else if (stat.count_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = tsi_pkg::ST_PAST;
               end else begin
                  cmd.scan_first = 1'b1;
               end
            end
         end
         tsi_pkg::S_SCAN_CMP: begin
            if (stat.hit) begin
               cmd.cap_cur = 1'b1;
               if (stat.idx_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = tsi_pkg::ST_FIRST;
               end else if (stat.zero_interval) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = tsi_pkg::ST_ZERO;
               end
            end else begin
               cmd.scan_next = 1'b1;
               if (stat.last_entry) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = tsi_pkg::ST_PAST;
               end
            end
         end
         tsi_pkg::S_PREV_RD:  cmd.rd_prev  = 1'b1;
         tsi_pkg::S_PREV_CAP: cmd.cap_prev = 1'b1;
         tsi_pkg::S_DIV:      cmd.div_step = 1'b1;
         tsi_pkg::S_MUL:      cmd.mul_step = 1'b1;
         tsi_pkg::S_ACC: begin
            cmd.acc_step = 1'b1;
            if (stat.lane_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = tsi_pkg::ST_INTERP;
            end
         end
         tsi_pkg::S_DONE: cmd.out_load = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/tsi_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsi_dp
// Sample tables, walk index, serial divider, shared blend multiplier and
// result register.
// ----------------------------------------------------------------------------
module tsi_dp #(
   parameter int TABLE_DEPTH = tsi_pkg::TABLE_DEPTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_cmd,
   input  wire  [9:0]                           in_index,
   input  wire  [tsi_pkg::TIME_W-1:0]           in_time,
   input  wire  [tsi_pkg::ANG_WORD_W-1:0]       in_angles,
   input  wire  [tsi_pkg::CNT_W-1:0]            sample_count,
   input  tsi_pkg::ctl_cmd_type                 cmd,
   output tsi_pkg::dp_stat_type                 stat,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [2:0]                           rsp_status,
   output logic [tsi_pkg::TIME_W-1:0]           rsp_time,
   output logic [tsi_pkg::ANG_WORD_W-1:0]       rsp_angles
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = tsi_pkg::ANGLE_W;
   localparam int TW = tsi_pkg::TIME_W;
   localparam int NA = tsi_pkg::NUM_ANGLES;

   logic [TW-1:0]                     time_mem [TABLE_DEPTH];
   logic [tsi_pkg::ANG_WORD_W-1:0]    ang_mem  [TABLE_DEPTH];

   logic [TW-1:0]                     rd_time_ff;
   logic [tsi_pkg::ANG_WORD_W-1:0]    rd_ang_ff;
   logic [TW-1:0]                     qtime_ff, prev_time_ff, t1_ff, d_ff;
   logic [IW-1:0]                     idx_ff;
   logic [CW-1:0]                     count_ff;
   logic [tsi_pkg::ANG_WORD_W-1:0]    cur_ang_ff, prev_ang_ff;
   logic [TW:0]                       rem_ff;
   logic [tsi_pkg::S_W-1:0]           q_ff;
   logic [4:0]                        div_cnt_ff;
   logic [tsi_pkg::LANE_W-1:0]        lane_ff;
   logic signed [tsi_pkg::PROD_W-1:0] prod_ff;
   logic [TW-1:0]                     res_time_ff;
   logic [tsi_pkg::ANG_WORD_W-1:0]    res_ang_ff;
   tsi_pkg::status_type               status_ff;
   logic                              out_valid_ff;
   logic [2:0]                        out_status_ff;
   logic [TW-1:0]                     out_time_ff;
   logic [tsi_pkg::ANG_WORD_W-1:0]    out_ang_ff;

   logic [IW-1:0]                     rd_addr;
   logic                              wr_en;
   logic [16:0]                       count_lim;
   logic                              div_ge;
   logic [TW:0]                       div_sel;
   logic signed [tsi_pkg::DIFF_W-1:0] lane_diff, lane_base;
   logic signed [tsi_pkg::PROD_W-1:0] rounded;
   logic signed [tsi_pkg::DIFF_W+1:0] blend_sum;
   logic signed [AW:0]                w_cur, w_prev;
   logic [AW-1:0]                     a_cur, a_prev;
   logic [1:0]                        ang_sel;
   logic                              keep_vals;

   assign rd_addr = cmd.rd_prev ? idx_ff - IW'(1) : idx_ff;
   assign wr_en   = cmd.take_item && !in_cmd &&
                    ({7'd0, in_index} < 17'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[IW'(in_index)] <= in_time;
         ang_mem[IW'(in_index)]  <= in_angles;
      end
      rd_time_ff <= time_mem[rd_addr];
      rd_ang_ff  <= ang_mem[rd_addr];
   end

   assign count_lim = ({6'd0, sample_count} > 17'(TABLE_DEPTH)) ?
                      17'(TABLE_DEPTH) : {6'd0, sample_count};

   // One quotient bit per cycle; the remainder stays below twice the divisor.
   assign div_ge  = rem_ff >= {1'b0, d_ff};
   assign div_sel = div_ge ? rem_ff - {1'b0, d_ff} : rem_ff;

   assign ang_sel = 2'(lane_ff - tsi_pkg::LANE_W'(1));
   assign a_cur   = cur_ang_ff[AW*ang_sel +: AW];
   assign a_prev  = prev_ang_ff[AW*ang_sel +: AW];
   // North is the last angle lane and is blended unwrapped.
   assign w_cur   = (ang_sel == 2'(NA - 1)) ? (AW+1)'($signed(a_cur)) :
                    tsi_pkg::wrap_angle($signed(a_cur));
   assign w_prev  = (ang_sel == 2'(NA - 1)) ? (AW+1)'($signed(a_prev)) :
                    tsi_pkg::wrap_angle($signed(a_prev));

   always_comb begin
      if (lane_ff == '0) begin
         lane_diff = $signed({2'b00, d_ff});
         lane_base = $signed({2'b00, prev_time_ff});
      end else begin
         lane_diff = tsi_pkg::DIFF_W'(w_cur) - tsi_pkg::DIFF_W'(w_prev);
         lane_base = tsi_pkg::DIFF_W'(w_prev);
      end
   end

   assign rounded   = (prod_ff + tsi_pkg::PROD_W'(32768)) >>> tsi_pkg::FRAC_W;
   assign blend_sum = (tsi_pkg::DIFF_W+2)'(lane_base) + (tsi_pkg::DIFF_W+2)'(rounded);

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         qtime_ff <= in_time;
         count_ff <= CW'(count_lim);
      end
      if (cmd.scan_first) begin
         idx_ff       <= '0;
         prev_time_ff <= '0;
      end
      if (cmd.scan_next) begin
         idx_ff       <= idx_ff + IW'(1);
         prev_time_ff <= rd_time_ff;
      end
      if (cmd.cap_cur) begin
         t1_ff       <= rd_time_ff;
         cur_ang_ff  <= rd_ang_ff;
         res_time_ff <= rd_time_ff;
         res_ang_ff  <= rd_ang_ff;
      end
      if (cmd.cap_prev) begin
         prev_ang_ff <= rd_ang_ff;
         d_ff        <= t1_ff - prev_time_ff;
         rem_ff      <= {1'b0, qtime_ff - prev_time_ff};
         q_ff        <= '0;
         div_cnt_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= {div_sel[TW-1:0], 1'b0};
         q_ff       <= {q_ff[tsi_pkg::S_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 5'd1;
         lane_ff    <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff <= tsi_pkg::PROD_W'(lane_diff * $signed({1'b0, q_ff}));
      end
      if (cmd.acc_step) begin
         if (lane_ff == '0) res_time_ff <= blend_sum[TW-1:0];
         else res_ang_ff[AW*ang_sel +: AW] <= blend_sum[AW-1:0];
         lane_ff <= lane_ff + tsi_pkg::LANE_W'(1);
      end
      if (cmd.set_status) status_ff <= cmd.status;
   end

   assign keep_vals = (status_ff == tsi_pkg::ST_INTERP) || (status_ff == tsi_pkg::ST_FIRST);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_time_ff   <= keep_vals ? res_time_ff : '0;
         out_ang_ff    <= keep_vals ? res_ang_ff : '0;
      end
   end

   assign stat.is_query      = in_cmd;
   assign stat.count_zero    = (sample_count == '0);
   assign stat.hit           = rd_time_ff >= qtime_ff;
   assign stat.idx_zero      = (idx_ff == '0);
   assign stat.zero_interval = rd_time_ff <= prev_time_ff;
   assign stat.last_entry    = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign stat.div_last      = (div_cnt_ff == 5'(tsi_pkg::DIV_STEPS - 1));
   assign stat.lane_last     = (lane_ff == tsi_pkg::LANE_LAST);
   assign stat.out_free      = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_time   = out_time_ff;
   assign rsp_angles = out_ang_ff;

endmodule
`default_nettype wire

>>> hdl/timed_sample_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_sample_interpolator_unit
// Time-stamped orientation table with linear interpolation at a query time.
// ----------------------------------------------------------------------------
// Each request word is either a load (tuser = 0), which writes one table
// entry, or a query (tuser = 1), which returns the orientation at the given
// time. Every request word produces exactly one response word, whose tuser
// field carries the status code.
// A load goes from the request straight to the result step. A query walks
// the table from entry 0, reading and then comparing each entry on the
// single read port of the table memories; an interpolated result adds a
// read of the earlier neighbor, the restoring divider that forms the weight
// and the shared blend multiplier (five lanes, a multiply and an accumulate
// each). One request is in work at a time.
// Reset clears the sequencer and the response valid flag and sets
// sample_count to 1024; the table is not cleared, and entries must be loaded
// before a query reads them. The response sits in an output register, so the
// next request is taken while the previous response waits for the receiver;
// a stalled receiver only holds the block in its final step.
// ----------------------------------------------------------------------------
module timed_sample_interpolator_unit #(
   parameter int TABLE_DEPTH = tsi_pkg::TABLE_DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   // Request words.
   input  wire          req_tvalid,
   output logic         req_tready,
   // [9:0] entry_index, [41:10] sample_time, [67:42] alpha_in,
   // [93:68] beta_in, [119:94] gamma_in, [145:120] north_in, rest zero.
   input  wire  [151:0] req_tdata,
   // [0] cmd.
   input  wire  [0:0]   req_tuser,
   // Response words.
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [31:0] time_out, [57:32] alpha_out, [83:58] beta_out,
   // [109:84] gamma_out, [135:110] north_out.
   output logic [135:0] rsp_tdata,
   // [2:0] status.
   output logic [2:0]   rsp_tuser,
   // Register port.
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [1:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [tsi_pkg::CNT_W-1:0] sample_count_ff;
   logic                      csr_wr;
   tsi_pkg::ctl_cmd_type      cmd;
   tsi_pkg::dp_stat_type      stat;

   // The register is written in the access phase of a write transfer.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == tsi_pkg::REG_SAMPLE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= tsi_pkg::SAMPLE_COUNT_RST;
      end else if (csr_wr) begin
         sample_count_ff <= csr_pwdata[tsi_pkg::CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == tsi_pkg::REG_SAMPLE_COUNT) ?
                       {21'd0, sample_count_ff} : 32'd0;

   tsi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tsi_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .in_cmd       (req_tuser[0]),
      .in_index     (req_tdata[9:0]),
      .in_time      (req_tdata[41:10]),
      .in_angles    (req_tdata[145:42]),
      .sample_count (sample_count_ff),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_time     (rsp_tdata[31:0]),
      .rsp_angles   (rsp_tdata[135:32])
   );

endmodule
`default_nettype wire
